>>> hdl/rectilinear_grid_bilinear_sample_macros.svh
// Assertion macros for the rectilinear grid bilinear sampler.
// No dependencies.
`ifndef RECTILINEAR_GRID_BILINEAR_SAMPLE_MACROS_SVH
`define RECTILINEAR_GRID_BILINEAR_SAMPLE_MACROS_SVH
// implication checked every clock, off during reset
`define RGB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define RGB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> hdl/rgbs_pkg.sv
// Shared types and constants for the rectilinear grid bilinear sampler.
// No dependencies.
package rgbs_pkg;
	localparam int MaxColumns = 64;
	localparam int MaxRows    = 64;
	localparam int ColW       = $clog2(MaxColumns);
	localparam int RowW       = $clog2(MaxRows);
	localparam int StoreW     = ColW + RowW;
	// weight divider width: one quotient bit per stage, |num|*2^16 plus rounding
	localparam int DivW       = 50;

	typedef enum logic [1:0] {
		CMD_WR_COL = 2'd0,
		CMD_WR_ROW = 2'd1,
		CMD_WR_HGT = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	localparam logic [0:0] REG_COLUMNS = 1'b0;
	localparam logic [0:0] REG_ROWS    = 1'b1;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

>>> hdl/rgbs_div.sv
// Pipelined restoring divider for the Q16.16 weights, one quotient bit per stage.
// Depends on rgbs_pkg; stalls with the rest of the pipe through en.
module rgbs_div
	import rgbs_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic signed [32:0] num,
	input  logic signed [32:0] den,
	output logic signed [31:0] weight
);
	localparam int QW = DivW; // |num|*2^16 plus rounding fits here
	localparam int NS = QW;

	logic [QW-1:0] rem_s [NS+1];
	logic [QW-1:0] quo_s [NS+1];
	logic [32:0]   den_s [NS+1];
	logic          neg_s [NS+1];
	logic          zero_s [NS+1];

	logic [32:0] an, ad;
	always_comb begin
		an = num[32] ? 33'(-num) : 33'(num);
		ad = den[32] ? 33'(-den) : 33'(den);
	end

	// dividend = |num|*2^16 + |den|/2, quotient is the rounded weight
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			quo_s[0]  <= QW'({an, 16'b0}) + QW'(ad[32:1]);
			den_s[0]  <= ad;
			neg_s[0]  <= num[32] ^ den[32];
			zero_s[0] <= (den == '0);
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_st
		logic [QW:0] sh;
		logic [QW:0] df;
		always_comb begin
			sh = {rem_s[k], quo_s[k][QW-1]};
			df = sh - (QW+1)'(den_s[k]);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= df[QW] ? sh[QW-1:0] : df[QW-1:0];
				quo_s[k+1]  <= {quo_s[k][QW-2:0], ~df[QW]};
				den_s[k+1]  <= den_s[k];
				neg_s[k+1]  <= neg_s[k];
				zero_s[k+1] <= zero_s[k];
			end
		end
	end

	logic [QW-1:0] q;
	always_comb begin
		q = quo_s[NS];
		if (q > QW'(33'h80000000)) q = QW'(33'h80000000);
		if (!neg_s[NS] && q > QW'(32'h7fffffff)) q = QW'(32'h7fffffff);
		if (zero_s[NS]) weight = '0;
		else if (neg_s[NS]) weight = 32'(-q);
		else weight = q[31:0];
	end
endmodule

>>> hdl/rectilinear_grid_bilinear_sample.sv
// Top level of the rectilinear grid bilinear sampler.
// Depends on rgbs_pkg, rgbs_div and the assertion macro header.
//
// Use: beats arrive on s_axis (command, index, value, query point). Write
// beats fill the column, row and height stores and give no result; a query
// beat gives one result beat on m_axis: height and the clamped cell indices.
// Configuration (column/row counts) is written through cfg_we/cfg_addr/
// cfg_wdata, which the user must do only while the pipe is empty (unchecked).
// Throughput: one beat per cycle unless the pipe freezes (see below), except
// that a write beat waits while a query sits in s1 or s2, as those stages
// still read the stores. A query passes through search, clamp and corner
// fetch, the bit-per-stage weight divider and four blend stages.
// The column search compares all used coordinates at once, then a priority
// encode picks the cell. Heights are held in four full copies so the four
// corners read at once; a height write goes to every copy.
// Reset clears only the pipe valid bits and the registers (both to 2); the
// stores are undefined until written. While m_axis_tvalid is high and
// m_axis_tready low the whole pipe freezes; s_axis_tready drops with it, so
// nothing is lost or repeated. A write commits on acceptance.
`include "rectilinear_grid_bilinear_sample_macros.svh"
module rectilinear_grid_bilinear_sample
	import rgbs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command[1:0], entry_index[13:2], entry_value[45:14], query_x[77:46],
	// query_y[109:78], zero fill
	input  logic [111:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// height[31:0], cell_column[37:32], cell_row[43:38], zero fill
	output logic [47:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic [6:0]   cfg_wdata
);
	localparam int DivLat = DivW + 1;
	localparam int NPipe  = DivLat + 7;

	logic [NPipe-1:0] v_q;
	logic en;
	logic hold_wr;
	logic acc;

	cmd_t               cmd;
	logic [11:0]        idx;
	logic signed [31:0] val, qx, qy;
	assign cmd = cmd_t'(s_axis_tdata[1:0]);
	assign idx = s_axis_tdata[13:2];
	assign val = s_axis_tdata[45:14];
	assign qx  = s_axis_tdata[77:46];
	assign qy  = s_axis_tdata[109:78];

	assign en = m_axis_tready || !m_axis_tvalid;
	// a write waits while a query in s1/s2 has yet to read coordinates or heights
	assign hold_wr = (cmd != CMD_QUERY) && (v_q[0] || v_q[1]);
	assign s_axis_tready = en && !hold_wr;
	assign acc = s_axis_tvalid && s_axis_tready;

	// configuration
	logic [6:0] cols_q, rows_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 7'd2;
			rows_q <= 7'd2;
		end else if (cfg_we) begin
			if (cfg_addr == REG_COLUMNS) cols_q <= cfg_wdata;
			else rows_q <= cfg_wdata;
		end
	end
	logic [6:0] nx, ny;
	always_comb begin
		nx = (cols_q < 7'd2) ? 7'd2 : (cols_q > 7'(MaxColumns)) ? 7'(MaxColumns) : cols_q;
		ny = (rows_q < 7'd2) ? 7'd2 : (rows_q > 7'(MaxRows)) ? 7'(MaxRows) : rows_q;
	end

	// coordinate registers, compared in parallel (each entry at a fixed place)
	logic signed [31:0] xc_q [MaxColumns];
	logic signed [31:0] yc_q [MaxRows];
	always_ff @(posedge clk) begin
		if (acc && cmd == CMD_WR_COL && idx < 12'(MaxColumns)) xc_q[idx[ColW-1:0]] <= val;
		if (acc && cmd == CMD_WR_ROW && idx < 12'(MaxRows))    yc_q[idx[RowW-1:0]] <= val;
	end

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[NPipe-2:0], acc && cmd == CMD_QUERY};
	end

	// s1: compare masks
	logic [MaxColumns-1:0] gx_s1;
	logic [MaxRows-1:0]    gy_s1;
	logic signed [31:0]    qx_s1, qy_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < MaxColumns; t++)
				gx_s1[t] <= (xc_q[t] > qx) && (7'(t) < nx);
			for (int t = 0; t < MaxRows; t++)
				gy_s1[t] <= (yc_q[t] > qy) && (7'(t) < ny);
			qx_s1 <= qx;
			qy_s1 <= qy;
		end
	end

	// s2: first set bit, clamp
	logic [ColW-1:0] ci;
	logic [RowW-1:0] rj;
	always_comb begin
		logic [6:0] k;
		k = nx;
		for (int t = MaxColumns-1; t >= 0; t--) if (gx_s1[t]) k = 7'(t);
		if (k == 0) k = 7'd1;
		k = k - 7'd1;
		if (k > nx - 7'd2) k = nx - 7'd2;
		ci = k[ColW-1:0];
	end
	always_comb begin
		logic [6:0] k;
		k = ny;
		for (int t = MaxRows-1; t >= 0; t--) if (gy_s1[t]) k = 7'(t);
		if (k == 0) k = 7'd1;
		k = k - 7'd1;
		if (k > ny - 7'd2) k = ny - 7'd2;
		rj = k[RowW-1:0];
	end
	logic [ColW-1:0]    i_s2;
	logic [RowW-1:0]    j_s2;
	logic signed [31:0] qx_s2, qy_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			i_s2 <= ci; j_s2 <= rj; qx_s2 <= qx_s1; qy_s2 <= qy_s1;
		end
	end

	// s3: fetch cell corners, form numerators and widths, address heights
	logic signed [32:0] nxm_s3, dx_s3, nym_s3, dy_s3;
	logic [ColW-1:0]    i_s3;
	logic [RowW-1:0]    j_s3;
	logic [12:0]        a00_s3;
	logic [6:0]         nx_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			nxm_s3 <= 33'(qx_s2) - 33'(xc_q[i_s2]);
			dx_s3  <= 33'(xc_q[i_s2 + 1'b1]) - 33'(xc_q[i_s2]);
			nym_s3 <= 33'(qy_s2) - 33'(yc_q[j_s2]);
			dy_s3  <= 33'(yc_q[j_s2 + 1'b1]) - 33'(yc_q[j_s2]);
			a00_s3 <= 13'(j_s2) * 13'(nx) + 13'(i_s2);
			nx_s3  <= nx;
			i_s3   <= i_s2;
			j_s3   <= j_s2;
		end
	end

	logic signed [31:0] tx, ty;
	rgbs_div u_divx (.clk, .en, .num(nxm_s3), .den(dx_s3), .weight(tx));
	rgbs_div u_divy (.clk, .en, .num(nym_s3), .den(dy_s3), .weight(ty));

	// height store: four copies so four corners read at once; write all copies
	logic signed [31:0] hm0 [1<<StoreW];
	logic signed [31:0] hm1 [1<<StoreW];
	logic signed [31:0] hm2 [1<<StoreW];
	logic signed [31:0] hm3 [1<<StoreW];
	logic [StoreW-1:0] a00, a01, a10, a11;
	assign a00 = a00_s3[StoreW-1:0];
	assign a10 = StoreW'(a00_s3 + 13'd1);
	assign a01 = StoreW'(a00_s3 + 13'(nx_s3));
	assign a11 = StoreW'(a00_s3 + 13'(nx_s3) + 13'd1);
	logic signed [31:0] z00_s4, z10_s4, z01_s4, z11_s4;
	always_ff @(posedge clk) begin
		if (acc && cmd == CMD_WR_HGT && 13'(idx) < 13'(MaxColumns * MaxRows)) begin
			hm0[idx[StoreW-1:0]] <= val;
			hm1[idx[StoreW-1:0]] <= val;
			hm2[idx[StoreW-1:0]] <= val;
			hm3[idx[StoreW-1:0]] <= val;
		end
		if (en) begin
			z00_s4 <= hm0[a00];
			z10_s4 <= hm1[a10];
			z01_s4 <= hm2[a01];
			z11_s4 <= hm3[a11];
		end
	end

	// delay corners to meet the weights, indices to meet the blended height
	localparam int DL = DivLat - 1;
	logic signed [31:0] z00_d [DL], z10_d [DL], z01_d [DL], z11_d [DL];
	logic [ColW-1:0] i_d [DL+4];
	logic [RowW-1:0] j_d [DL+4];
	always_ff @(posedge clk) begin
		if (en) begin
			z00_d[0] <= z00_s4; z10_d[0] <= z10_s4;
			z01_d[0] <= z01_s4; z11_d[0] <= z11_s4;
			i_d[0] <= i_s3; j_d[0] <= j_s3;
			for (int k = 1; k < DL; k++) begin
				z00_d[k] <= z00_d[k-1]; z10_d[k] <= z10_d[k-1];
				z01_d[k] <= z01_d[k-1]; z11_d[k] <= z11_d[k-1];
			end
			for (int k = 1; k <= DL + 3; k++) begin
				i_d[k] <= i_d[k-1]; j_d[k] <= j_d[k-1];
			end
		end
	end

	// blend x: product registered, then round and add
	logic signed [65:0] pa_s5, pb_s5;
	logic signed [31:0] z00_s5, z01_s5, ty_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s5  <= 66'(tx) * 66'(33'(z10_d[DL-1]) - 33'(z00_d[DL-1]));
			pb_s5  <= 66'(tx) * 66'(33'(z11_d[DL-1]) - 33'(z01_d[DL-1]));
			z00_s5 <= z00_d[DL-1];
			z01_s5 <= z01_d[DL-1];
			ty_s5  <= ty;
		end
	end
	logic signed [31:0] a_s6, b_s6, ty_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			a_s6  <= sat32(66'(z00_s5) + ((pa_s5 + 66'sd32768) >>> 16));
			b_s6  <= sat32(66'(z01_s5) + ((pb_s5 + 66'sd32768) >>> 16));
			ty_s6 <= ty_s5;
		end
	end
	logic signed [65:0] ph_s7;
	logic signed [31:0] a_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			ph_s7 <= 66'(ty_s6) * 66'(33'(b_s6) - 33'(a_s6));
			a_s7  <= a_s6;
		end
	end
	logic signed [31:0] h_s8;
	logic [ColW-1:0] i_s8;
	logic [RowW-1:0] j_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			h_s8 <= sat32(66'(a_s7) + ((ph_s7 + 66'sd32768) >>> 16));
			i_s8 <= i_d[DL+3];
			j_s8 <= j_d[DL+3];
		end
	end

	assign m_axis_tvalid = v_q[NPipe-1];
	assign m_axis_tdata  = {4'b0, j_s8, i_s8, h_s8};

	`RGB_ASSERT_IMP(a_cell_col, clk, arst_n, m_axis_tvalid, 7'(i_s8) <= nx - 7'd2, "column out of range")
	`RGB_ASSERT_IMP(a_cell_row, clk, arst_n, m_axis_tvalid, 7'(j_s8) <= ny - 7'd2, "row out of range")
	`RGB_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stall lost beat")
endmodule
